// ===== rtl/core/irst_pkg.sv =====
// Shared types and constants of the inverse rigid scale transform.
// No dependencies; every other file of the block uses it.
`default_nettype none
package irst_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAT_FRAC  = 28;
	localparam int DIV_SHIFT = MAT_FRAC - FRAC_BITS;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int QCOMP_W = 16;
	localparam int ENT_W   = 31;
	localparam int PROD_W  = DIFF_W + ENT_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int MAG_W   = 64;
	localparam int SCALE_W = 31;
	localparam int QBITS   = 33;

	// front stages: input, difference, products, sums, magnitude
	localparam int NFRONT = 5;
	// divider: rounding add, overflow check, one stage per quotient bit, result
	localparam int NSTG   = NFRONT + 2 + QBITS + 1;

	typedef enum logic [2:0] {
		REG_QUAT    = 3'd0,
		REG_TRANS_X = 3'd1,
		REG_TRANS_Y = 3'd2,
		REG_TRANS_Z = 3'd3,
		REG_SCALE_X = 3'd4,
		REG_SCALE_Y = 3'd5,
		REG_SCALE_Z = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
	} pt_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      zero_scale;
	} pt_out_t;

	typedef logic [ENT_W-1:0] ent_t;
	typedef ent_t [2:0][2:0] mat_t;

	// per-axis data handed from the front to the divider
	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [MAG_W-1:0] mag;
	} fdat_t;

	// stage advance enables
	typedef struct packed {
		logic [NSTG-1:0] adv;
	} stg_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/irst_mat.sv =====
// Rotation matrix from the quaternion register, clamped entries, two register levels.
// Depends on irst_pkg.
`default_nettype none
module irst_mat (
	input  wire logic          clk,
	input  wire logic [63:0]   quat,
	output irst_pkg::mat_t     mat
);
	import irst_pkg::*;

	localparam int EW = 36;

	logic signed [QCOMP_W-1:0] r, i, j, k;
	logic signed [31:0] ii_q, jj_q, kk_q, ij_q, ik_q, jk_q, kr_q, jr_q, ir_q;
	logic signed [EW-1:0] one_c;
	mat_t mat_q;

	function automatic ent_t clampe(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] lim;
		lim = EW'(1) <<< (ENT_W - 2);
		if (v > lim)
			return ENT_W'(lim);
		else if (v < -lim)
			return ENT_W'(-lim);
		return ENT_W'(v);
	endfunction

	assign r = quat[63:48];
	assign i = quat[47:32];
	assign j = quat[31:16];
	assign k = quat[15:0];
	assign one_c = EW'(1) <<< MAT_FRAC;

	// quaternion products, free running
	always_ff @(posedge clk) begin
		ii_q <= i * i;
		jj_q <= j * j;
		kk_q <= k * k;
		ij_q <= i * j;
		ik_q <= i * k;
		jk_q <= j * k;
		kr_q <= k * r;
		jr_q <= j * r;
		ir_q <= i * r;
	end

	// matrix entries, Q.28
	always_ff @(posedge clk) begin
		mat_q[0][0] <= clampe(one_c - 2 * (EW'(jj_q) + EW'(kk_q)));
		mat_q[0][1] <= clampe(2 * (EW'(ij_q) - EW'(kr_q)));
		mat_q[0][2] <= clampe(2 * (EW'(ik_q) + EW'(jr_q)));
		mat_q[1][0] <= clampe(2 * (EW'(ij_q) + EW'(kr_q)));
		mat_q[1][1] <= clampe(one_c - 2 * (EW'(ii_q) + EW'(kk_q)));
		mat_q[1][2] <= clampe(2 * (EW'(jk_q) - EW'(ir_q)));
		mat_q[2][0] <= clampe(2 * (EW'(ik_q) - EW'(jr_q)));
		mat_q[2][1] <= clampe(2 * (EW'(jk_q) + EW'(ir_q)));
		mat_q[2][2] <= clampe(one_c - 2 * (EW'(ii_q) + EW'(jj_q)));
	end

	assign mat = mat_q;

endmodule
`default_nettype wire

// ===== rtl/core/irst_front.sv =====
// Front pipeline: translation subtract, transpose multiply, axis sums, magnitude.
// Depends on irst_pkg.
`default_nettype none
module irst_front (
	input  wire logic                 clk,
	input  wire irst_pkg::stg_ctl_t   ctl,
	input  wire irst_pkg::pt_in_t     in_data,
	input  wire logic [31:0]          trans_x,
	input  wire logic [31:0]          trans_y,
	input  wire logic [31:0]          trans_z,
	input  wire irst_pkg::mat_t       mat,
	output irst_pkg::fdat_t [2:0]     fd
);
	import irst_pkg::*;

	pt_in_t in_s1;
	logic signed [DIFF_W-1:0] d_s2 [3];
	logic signed [PROD_W-1:0] p_s3 [3][3];
	logic signed [SUM_W-1:0]  sum_s4 [3];
	fdat_t [2:0] fd_s5;

	// input register
	always_ff @(posedge clk) begin
		if (ctl.adv[0])
			in_s1 <= in_data;
	end

	// difference to translation
	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			d_s2[0] <= DIFF_W'(in_s1.in_x) - DIFF_W'($signed(trans_x));
			d_s2[1] <= DIFF_W'(in_s1.in_y) - DIFF_W'($signed(trans_y));
			d_s2[2] <= DIFF_W'(in_s1.in_z) - DIFF_W'($signed(trans_z));
		end
	end

	// products R[b][a] * d[b]
	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			for (int a = 0; a < 3; a++)
				for (int b = 0; b < 3; b++)
					p_s3[a][b] <= $signed(mat[b][a]) * d_s2[b];
		end
	end

	// axis sums
	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			for (int a = 0; a < 3; a++)
				sum_s4[a] <= SUM_W'(p_s3[a][0]) + SUM_W'(p_s3[a][1]) + SUM_W'(p_s3[a][2]);
		end
	end

	// sign, zero and magnitude
	always_ff @(posedge clk) begin
		if (ctl.adv[4]) begin
			for (int a = 0; a < 3; a++) begin
				fd_s5[a].neg  <= sum_s4[a][SUM_W-1];
				fd_s5[a].zero <= (sum_s4[a] == '0);
				fd_s5[a].mag  <= sum_s4[a][SUM_W-1] ? MAG_W'(-sum_s4[a]) : MAG_W'(sum_s4[a]);
			end
		end
	end

	assign fd = fd_s5;

endmodule
`default_nettype wire

// ===== rtl/core/irst_div.sv =====
// Pipelined restoring divider for one axis, one quotient bit per stage, with rounding
// and saturation. Depends on irst_pkg.
`default_nettype none
module irst_div (
	input  wire logic                       clk,
	input  wire irst_pkg::stg_ctl_t         ctl,
	input  wire irst_pkg::fdat_t            fd,
	input  wire logic [irst_pkg::SCALE_W-1:0] scale,
	output logic [irst_pkg::COORD_W-1:0]    res,
	output logic                            zflag
);
	import irst_pkg::*;

	localparam int PAD = MAG_W - SCALE_W;
	localparam logic [QBITS-1:0] QMAX_POS = QBITS'(32'h7FFF_FFFF);
	localparam logic [QBITS-1:0] QMAX_NEG = QBITS'(33'h0_8000_0000);

	logic [MAG_W-1:0] sc_w;
	logic [MAG_W-1:0] half;
	logic [MAG_W-1:0] num_s6;
	logic             neg_s6, nz_s6;
	logic [MAG_W-1:0] rem_s7;
	logic             neg_s7, nz_s7, ovf_s7;

	logic [MAG_W-1:0] rem_sx [QBITS];
	logic [QBITS-1:0] quo_sx [QBITS];
	logic             neg_sx [QBITS];
	logic             nz_sx  [QBITS];
	logic             ovf_sx [QBITS];

	logic [COORD_W-1:0] res_q;
	logic               zf_q;
	logic [COORD_W-1:0] res_c;
	logic [QBITS-1:0]   qf;

	assign sc_w = {{PAD{1'b0}}, scale};
	assign half = (sc_w << DIV_SHIFT) >> 1;

	// rounding: add half the divisor
	always_ff @(posedge clk) begin
		if (ctl.adv[NFRONT]) begin
			num_s6 <= fd.mag + half;
			neg_s6 <= fd.neg;
			nz_s6  <= !fd.zero;
		end
	end

	// drop low divisor zeros, flag quotients beyond QBITS
	always_ff @(posedge clk) begin
		if (ctl.adv[NFRONT+1]) begin
			rem_s7 <= num_s6 >> DIV_SHIFT;
			ovf_s7 <= (num_s6 >> DIV_SHIFT) >= (sc_w << QBITS);
			neg_s7 <= neg_s6;
			nz_s7  <= nz_s6;
		end
	end

	// quotient bit stages, most significant bit first
	for (genvar t = 0; t < QBITS; t++) begin : g_bit
		localparam int KB = QBITS - 1 - t;
		logic [MAG_W-1:0] rem_in;
		logic [QBITS-1:0] quo_in;
		logic             neg_in, nz_in, ovf_in;
		logic [MAG_W-1:0] dsh;

		if (t == 0) begin : g_first
			assign rem_in = rem_s7;
			assign quo_in = '0;
			assign neg_in = neg_s7;
			assign nz_in  = nz_s7;
			assign ovf_in = ovf_s7;
		end else begin : g_next
			assign rem_in = rem_sx[t-1];
			assign quo_in = quo_sx[t-1];
			assign neg_in = neg_sx[t-1];
			assign nz_in  = nz_sx[t-1];
			assign ovf_in = ovf_sx[t-1];
		end

		assign dsh = sc_w << KB;

		always_ff @(posedge clk) begin
			if (ctl.adv[NFRONT+2+t]) begin
				if (rem_in >= dsh) begin
					rem_sx[t]     <= rem_in - dsh;
					quo_sx[t]     <= quo_in | (QBITS'(1) << KB);
				end else begin
					rem_sx[t]     <= rem_in;
					quo_sx[t]     <= quo_in;
				end
				neg_sx[t] <= neg_in;
				nz_sx[t]  <= nz_in;
				ovf_sx[t] <= ovf_in;
			end
		end
	end

	// sign and saturation
	assign qf = quo_sx[QBITS-1];
	always_comb begin
		if (scale == '0) begin
			if (!nz_sx[QBITS-1])
				res_c = '0;
			else if (neg_sx[QBITS-1])
				res_c = 32'h8000_0000;
			else
				res_c = 32'h7FFF_FFFF;
		end else if (neg_sx[QBITS-1]) begin
			if (ovf_sx[QBITS-1] || qf > QMAX_NEG)
				res_c = 32'h8000_0000;
			else
				res_c = COORD_W'(~qf + QBITS'(1));
		end else begin
			if (ovf_sx[QBITS-1] || qf > QMAX_POS)
				res_c = 32'h7FFF_FFFF;
			else
				res_c = COORD_W'(qf);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.adv[NSTG-1]) begin
			res_q <= res_c;
			zf_q  <= (scale == '0);
		end
	end

	assign res   = res_q;
	assign zflag = zf_q;

endmodule
`default_nettype wire

// ===== rtl/core/inverse_rigid_scale_transform.sv =====
// Inverse rigid scale transform: one point per cycle sustained while the output does
// not stall, set by the per-stage pipeline. The divider takes one quotient bit per
// stage; each stage holds while the one after it is full and stalled, so bubbles are
// squeezed out. Reset clears all valid bits and loads identity rotation, zero translation
// and unit scale.
// Depends on irst_pkg, irst_mat, irst_front, irst_div.
`default_nettype none
module inverse_rigid_scale_transform (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire irst_pkg::pt_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output irst_pkg::pt_out_t      out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [63:0]       cfg_data
);
	import irst_pkg::*;

	logic [63:0]          quat_q;
	logic [31:0]          trans_x_q, trans_y_q, trans_z_q;
	logic [SCALE_W-1:0]   scale_x_q, scale_y_q, scale_z_q;
	logic [NSTG-1:0]      vld_s;
	stg_ctl_t             ctl;
	mat_t                 mat;
	fdat_t [2:0]          fd;
	logic [COORD_W-1:0]   res_x, res_y, res_z;
	logic                 zf_x, zf_y, zf_z;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q    <= 64'h4000_0000_0000_0000;
			trans_x_q <= '0;
			trans_y_q <= '0;
			trans_z_q <= '0;
			scale_x_q <= SCALE_W'(1) << FRAC_BITS;
			scale_y_q <= SCALE_W'(1) << FRAC_BITS;
			scale_z_q <= SCALE_W'(1) << FRAC_BITS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_QUAT:    quat_q    <= cfg_data;
				REG_TRANS_X: trans_x_q <= cfg_data[31:0];
				REG_TRANS_Y: trans_y_q <= cfg_data[31:0];
				REG_TRANS_Z: trans_z_q <= cfg_data[31:0];
				REG_SCALE_X: scale_x_q <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y: scale_y_q <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Z: scale_z_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage advance: a stage moves when empty or when the next one moves
	assign ctl.adv[NSTG-1] = !vld_s[NSTG-1] || out_ready;
	for (genvar s = 0; s < NSTG - 1; s++) begin : g_adv
		assign ctl.adv[s] = !vld_s[s] || ctl.adv[s+1];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ctl.adv[0])
				vld_s[0] <= in_valid;
			for (int s = 1; s < NSTG; s++)
				if (ctl.adv[s])
					vld_s[s] <= vld_s[s-1];
		end
	end

	assign in_ready  = ctl.adv[0];
	assign out_valid = vld_s[NSTG-1];

	irst_mat u_mat (
		.clk  (clk),
		.quat (quat_q),
		.mat  (mat)
	);

	irst_front u_front (
		.clk     (clk),
		.ctl     (ctl),
		.in_data (in_data),
		.trans_x (trans_x_q),
		.trans_y (trans_y_q),
		.trans_z (trans_z_q),
		.mat     (mat),
		.fd      (fd)
	);

	irst_div u_div_x (
		.clk   (clk),
		.ctl   (ctl),
		.fd    (fd[0]),
		.scale (scale_x_q),
		.res   (res_x),
		.zflag (zf_x)
	);

	irst_div u_div_y (
		.clk   (clk),
		.ctl   (ctl),
		.fd    (fd[1]),
		.scale (scale_y_q),
		.res   (res_y),
		.zflag (zf_y)
	);

	irst_div u_div_z (
		.clk   (clk),
		.ctl   (ctl),
		.fd    (fd[2]),
		.scale (scale_z_q),
		.res   (res_z),
		.zflag (zf_z)
	);

	assign out_data.out_x      = res_x;
	assign out_data.out_y      = res_y;
	assign out_data.out_z      = res_z;
	assign out_data.zero_scale = zf_x | zf_y | zf_z;

endmodule
`default_nettype wire

// ===== rtl/core/irst_checker.sv =====
// Port-level checks of the inverse rigid scale transform, bound to the top level.
// Depends on irst_pkg and inverse_rigid_scale_transform.
`default_nettype none
module irst_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire irst_pkg::pt_out_t  out_data
);
	// stalled output transaction keeps valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// stalled output transaction keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// input can only be refused when the output is stalled
	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without output stall");

	// an empty output stage never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

endmodule

bind inverse_rigid_scale_transform irst_checker u_irst_checker (.*);
`default_nettype wire

// ===== dv/inverse_rigid_scale_transform_tb.sv =====
// Self-checking testbench for inverse_rigid_scale_transform: directed table, then random phases.
// Depends on irst_pkg and the RTL of the block; predicts untyped points with its own model.
`timescale 1ns / 100ps
`default_nettype none
module inverse_rigid_scale_transform_tb;
	import irst_pkg::*;

	localparam int          PERIOD     = 12;
	localparam int          HOLD_LEN   = 300;
	localparam int          DRAIN_WAIT = 50;
	localparam int          N_PHASES   = 8;
	localparam int          PHASE_PTS  = 50;
	localparam logic [2:0]  IDX_UNUSED = 3'd7;
	localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
	localparam logic [63:0] QUAT_IDENT = 64'h4000_0000_0000_0000;
	localparam logic [63:0] QUAT_ROT_Z = 64'h2D41_0000_0000_2D41;

	typedef enum logic {ROW_CFG, ROW_PT} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [63:0] val;
		pt_in_t      pt;
		bit          typed;
		pt_out_t     res;
	} stim_row_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	pt_in_t      in_data;
	pt_out_t     out_data;

	// local copy of the configuration
	logic [63:0]        quat_cfg;
	logic signed [31:0] shift_cfg [3];
	logic [30:0]        scale_cfg [3];

	pt_out_t   local_pts [$];
	stim_row_t stim_rows [$];
	int        err_count, miss_count, burst_left, idle_max, rx_mode;
	bit        hold_req;

	inverse_rigid_scale_transform DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	initial begin
		#50ms;
		$display("inverse_rigid_scale_transform_tb: done, errors");
		$finish;
	end

	// clamp a matrix entry to [-2.0, 2.0] in Q.28
	function automatic longint clamp_ent(longint v);
		longint lim = longint'(1) <<< 29;
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// rounded divide by scale, saturating; zero scale sets the flag
	function automatic logic [31:0] scale_div(longint n, logic [30:0] s, inout bit flag);
		logic [63:0] dv, mag, q;
		if (s == '0) begin
			flag = 1'b1;
			return (n > 0) ? S_MAX : ((n < 0) ? S_MIN : 32'd0);
		end
		dv  = {33'd0, s} << DIV_SHIFT;
		mag = (n < 0) ? 64'(-n) : 64'(n);
		q   = (mag + dv / 2) / dv;
		if (n < 0) return (q > 64'h8000_0000) ? S_MIN : 32'(-q);
		return (q > 64'h7FFF_FFFF) ? S_MAX : 32'(q);
	endfunction

	function automatic pt_out_t to_local(pt_in_t p);
		longint  r = $signed(quat_cfg[63:48]);
		longint  i = $signed(quat_cfg[47:32]);
		longint  j = $signed(quat_cfg[31:16]);
		longint  k = $signed(quat_cfg[15:0]);
		longint  one = longint'(1) <<< MAT_FRAC;
		longint  m [3][3];
		longint  d [3];
		longint  acc;
		logic [31:0] res [3];
		bit      flag = 1'b0;
		pt_out_t o;
		m[0][0] = one - 2 * (j * j + k * k);
		m[0][1] = 2 * (i * j - k * r);
		m[0][2] = 2 * (i * k + j * r);
		m[1][0] = 2 * (i * j + k * r);
		m[1][1] = one - 2 * (i * i + k * k);
		m[1][2] = 2 * (j * k - i * r);
		m[2][0] = 2 * (i * k - j * r);
		m[2][1] = 2 * (j * k + i * r);
		m[2][2] = one - 2 * (i * i + j * j);
		d[0] = longint'(p.in_x) - longint'(shift_cfg[0]);
		d[1] = longint'(p.in_y) - longint'(shift_cfg[1]);
		d[2] = longint'(p.in_z) - longint'(shift_cfg[2]);
		for (int a = 0; a < 3; a++) begin
			acc = 0;
			// transpose: column a of the rotation
			for (int b = 0; b < 3; b++) acc += clamp_ent(m[b][a]) * d[b];
			res[a] = scale_div(acc, scale_cfg[a], flag);
		end
		o.out_x = res[0];
		o.out_y = res[1];
		o.out_z = res[2];
		o.zero_scale = flag;
		return o;
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 6))
			0: return S_MIN;
			1: return S_MAX;
			2: return 32'd0;
			3: return $urandom;
			default: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
		endcase
	endfunction

	function automatic logic [30:0] pick_scale();
		case ($urandom_range(0, 7))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return 31'(ONE_Q16);
			3: return 31'($urandom);
			4: return 31'd1;
			default: return 31'($urandom_range(1 << 12, 1 << 19));
		endcase
	endfunction

	function automatic pt_in_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		pt_in_t p;
		p.in_x = x;
		p.in_y = y;
		p.in_z = z;
		return p;
	endfunction

	function automatic void add_cfg(logic [2:0] idx, logic [63:0] v);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.idx  = idx;
		row.val  = v;
		stim_rows.push_back(row);
	endfunction

	function automatic void add_pt(pt_in_t p, bit typed = 0, logic [31:0] ex = 0,
			logic [31:0] ey = 0, logic [31:0] ez = 0, logic zf = 0);
		stim_row_t row;
		row.kind  = ROW_PT;
		row.pt    = p;
		row.typed = typed;
		row.res   = {ex, ey, ez, zf};
		stim_rows.push_back(row);
	endfunction

	// config write transaction; caller makes sure the block is idle
	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_QUAT:    quat_cfg     = v;
			REG_TRANS_X: shift_cfg[0] = v[31:0];
			REG_TRANS_Y: shift_cfg[1] = v[31:0];
			REG_TRANS_Z: shift_cfg[2] = v[31:0];
			REG_SCALE_X: scale_cfg[0] = v[30:0];
			REG_SCALE_Y: scale_cfg[1] = v[30:0];
			REG_SCALE_Z: scale_cfg[2] = v[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// input transaction; valid stays up for a following point in the same burst
	task automatic send_point(pt_in_t p, bit typed = 0, pt_out_t res = '0);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, idle_max)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		in_valid = 1'b1;
		in_data  = p;
		do @(posedge clk); while (!in_ready);
		local_pts.push_back(typed ? res : to_local(p));
		burst_left--;
		@(negedge clk);
	endtask

	// stop sending and let every pending point come out
	task automatic drain();
		in_valid   = 1'b0;
		burst_left = 0;
		while (local_pts.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// receiver stall pattern, with an optional long hold-off
	initial begin
		int cnt;
		cnt = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				cnt++;
				case (rx_mode)
					0: out_ready = 1'b1;
					1: out_ready = 1'($urandom_range(0, 1));
					default: out_ready = (cnt % 7) < 3;
				endcase
			end
		end
	end

	// compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		pt_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (local_pts.size() == 0) begin
				err_count++;
				$display("unexpected output transaction %h", out_data);
			end else begin
				want = local_pts.pop_front();
				if (want.out_x !== out_data.out_x || want.out_y !== out_data.out_y ||
						want.out_z !== out_data.out_z ||
						want.zero_scale !== out_data.zero_scale) begin
					err_count++;
					miss_count++;
					if (miss_count <= 10)
						$display("mismatch: exp x=%h y=%h z=%h zs=%b  got x=%h y=%h z=%h zs=%b",
							want.out_x, want.out_y, want.out_z, want.zero_scale,
							out_data.out_x, out_data.out_y, out_data.out_z,
							out_data.zero_scale);
				end
			end
		end
	end

	initial begin
		stim_row_t row;
		err_count  = 0;
		miss_count = 0;
		burst_left = 0;
		idle_max   = 3;
		rx_mode    = 1;
		hold_req   = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		quat_cfg   = QUAT_IDENT;
		for (int a = 0; a < 3; a++) begin
			shift_cfg[a] = '0;
			scale_cfg[a] = 31'(ONE_Q16);
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity after reset: output equals input
		add_pt(pt(0, 0, 0), 1, 0, 0, 0, 0);
		add_pt(pt(S_MAX, S_MIN, -1), 1, S_MAX, S_MIN, -1, 0);
		add_pt(pt(S_MIN, S_MAX, 1), 1, S_MIN, S_MAX, 1, 0);
		add_pt(pt(ONE_Q16, -ONE_Q16, 32'h7FFF_0000), 1, ONE_Q16, -ONE_Q16, 32'h7FFF_0000, 0);
		// zero scale on every axis: sign saturation and the flag
		add_cfg(REG_SCALE_X, 0);
		add_cfg(REG_SCALE_Y, 0);
		add_cfg(REG_SCALE_Z, 0);
		add_pt(pt(5, -5, 0), 1, S_MAX, S_MIN, 0, 1);
		add_pt(pt(0, 0, 0), 1, 0, 0, 0, 1);
		// zero scale on one axis only
		add_cfg(REG_SCALE_X, ONE_Q16);
		add_cfg(REG_SCALE_Z, ONE_Q16);
		add_pt(pt(7, 9, 11), 1, 7, S_MAX, 11, 1);
		// extreme translation overflows the difference
		add_cfg(REG_SCALE_Y, ONE_Q16);
		add_cfg(REG_TRANS_X, {32'hFFFF_FFFF, S_MAX});
		add_cfg(REG_TRANS_Y, S_MIN);
		add_cfg(REG_TRANS_Z, 0);
		add_pt(pt(S_MIN, S_MAX, 0), 1, S_MIN, S_MAX, 0, 0);
		add_pt(pt(S_MAX, S_MIN, 3));
		// rotation about z, then non-unit quaternions that reach the clamp
		add_cfg(REG_TRANS_X, 0);
		add_cfg(REG_TRANS_Y, 32'h0003_8000);
		add_cfg(REG_QUAT, QUAT_ROT_Z);
		add_pt(pt(ONE_Q16, 0, 0));
		add_pt(pt(32'h0012_3456, 32'hFFF0_0000, 32'h0000_8000));
		add_cfg(REG_QUAT, 64'h7FFF_7FFF_7FFF_7FFF);
		add_pt(pt(ONE_Q16, ONE_Q16, ONE_Q16));
		add_pt(pt(S_MAX, S_MAX, S_MAX));
		add_cfg(REG_QUAT, 64'h8000_8000_8000_8000);
		add_pt(pt(S_MIN, S_MIN, S_MIN));
		// extreme scales: huge, tiny, half; unused index is ignored
		add_cfg(REG_SCALE_X, 31'h7FFF_FFFF);
		add_cfg(REG_SCALE_Y, 1);
		add_cfg(REG_SCALE_Z, 32'h0000_8000);
		add_cfg(IDX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		add_pt(pt(32'h0100_0000, 32'h0000_0003, 32'hFFFF_8001));
		add_pt(pt(-1, 1, 32'h0000_7FFF));

		foreach (stim_rows[n]) begin
			row = stim_rows[n];
			if (row.kind == ROW_CFG) begin
				drain();
				write_reg(row.idx, row.val);
			end else begin
				send_point(row.pt, row.typed, row.res);
			end
		end
		drain();

		// random phases: new settings each time, then a stream of points
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: write_reg(REG_QUAT, QUAT_IDENT);
				1: write_reg(REG_QUAT, {$urandom, $urandom});
				default: write_reg(REG_QUAT, {16'($urandom_range(0, 32767)) - 16'h4000,
					16'($urandom_range(0, 32767)) - 16'h4000,
					16'($urandom_range(0, 32767)) - 16'h4000,
					16'($urandom_range(0, 32767)) - 16'h4000});
			endcase
			write_reg(REG_TRANS_X, {$urandom, pick_coord()});
			write_reg(REG_TRANS_Y, {$urandom, pick_coord()});
			write_reg(REG_TRANS_Z, {$urandom, pick_coord()});
			// upper bits beyond the scale field are junk the block must drop
			write_reg(REG_SCALE_X, {$urandom, 1'($urandom_range(0, 1)), pick_scale()});
			write_reg(REG_SCALE_Y, {$urandom, 1'($urandom_range(0, 1)), pick_scale()});
			write_reg(REG_SCALE_Z, {$urandom, 1'($urandom_range(0, 1)), pick_scale()});
			if (ph == N_PHASES - 1) write_reg(IDX_UNUSED, {$urandom, $urandom});
			idle_max = (ph % 4 == 3) ? 0 : $urandom_range(1, 8);
			rx_mode  = (ph % 4 == 3) ? 0 : ph % 3;
			// receiver holds off while points keep coming, so the input stalls
			if (ph == 1) hold_req = 1'b1;
			for (int n = 0; n < PHASE_PTS; n++)
				send_point(pt(pick_coord(), pick_coord(), pick_coord()));
			drain();
		end

		if (err_count == 0 && local_pts.size() == 0)
			$display("inverse_rigid_scale_transform_tb: done, clean");
		else
			$display("inverse_rigid_scale_transform_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
